// ===== hdl/cdma_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cdma_pkg;

	localparam int DataW   = 32;
	localparam int OffW    = 6;
	localparam int AddrW   = 24;
	localparam int LenW    = 24;
	localparam int DmaLenW = 25;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_DONE  = 2'd2;

	localparam logic [1:0] SK_NONE  = 2'd0;
	localparam logic [1:0] SK_SRAM  = 2'd1;
	localparam logic [1:0] SK_FLASH = 2'd2;

	localparam logic [1:0] DK_NONE     = 2'd0;
	localparam logic [1:0] DK_TO_SAVE  = 2'd1;
	localparam logic [1:0] DK_FROM_SAVE = 2'd2;
	localparam logic [1:0] DK_ROM      = 2'd3;

	localparam logic [OffW-1:0] REG_RAM_ADDR  = 6'h00;
	localparam logic [OffW-1:0] REG_CART_ADDR = 6'h04;
	localparam logic [OffW-1:0] REG_TO_CART   = 6'h08;
	localparam logic [OffW-1:0] REG_TO_RAM    = 6'h0C;
	localparam logic [OffW-1:0] REG_STATUS    = 6'h10;
	localparam logic [OffW-1:0] REG_LAT0      = 6'h14;
	localparam logic [OffW-1:0] REG_PWD0      = 6'h18;
	localparam logic [OffW-1:0] REG_PGS0      = 6'h1C;
	localparam logic [OffW-1:0] REG_RLS0      = 6'h20;
	localparam logic [OffW-1:0] REG_LAT1      = 6'h24;
	localparam logic [OffW-1:0] REG_PWD1      = 6'h28;
	localparam logic [OffW-1:0] REG_PGS1      = 6'h2C;
	localparam logic [OffW-1:0] REG_RLS1      = 6'h30;

	localparam logic [DataW-1:0] SAVE_LO = 32'h0800_0000;
	localparam logic [DataW-1:0] SAVE_HI = 32'h0FFF_FFFF;
	localparam logic [DataW-1:0] ROM_LO  = 32'h1000_0000;
	localparam logic [DataW-1:0] ROM_HI  = 32'h1FBF_FFFF;

	typedef struct packed {
		logic [DataW-1:0]   read_data;
		logic               access_ok;
		logic               raise_irq;
		logic               clear_irq;
		logic [1:0]         dma_kind;
		logic               dma_save_flash;
		logic [AddrW-1:0]   dma_ram_addr;
		logic [DataW-1:0]   dma_cart_addr;
		logic [DmaLenW-1:0] dma_length;
	} res_t;

endpackage

`default_nettype wire

// ===== hdl/cart_dma_register_block_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel | Handshake         | Payload
// in      | in_valid/in_stall | opcode, reg_offset, write_data
// out     | out_valid/out_stall | read_data, access_ok, raise_irq, clear_irq, dma_*
// cfg     | cfg_wen           | cfg_wdata (storage kind)
//
// One word in and one word out per cycle while out_stall is low; each word
// passes the input register, then the result register. Register decode and
// address range compares sit between the two. Reset clears the register
// file, the storage kind and both valid flags. A stalled result holds; the input
// register keeps one word behind it, so in_stall rises only when both are full.

module cart_dma_register_block_core (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_wen,
	input  wire  [1:0]                      cfg_wdata,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  wire  [1:0]                      opcode,
	input  wire  [cdma_pkg::OffW-1:0]       reg_offset,
	input  wire  [cdma_pkg::DataW-1:0]      write_data,
	output logic                            out_valid,
	input  wire                             out_stall,
	output logic [cdma_pkg::DataW-1:0]      read_data,
	output logic                            access_ok,
	output logic                            raise_irq,
	output logic                            clear_irq,
	output logic [1:0]                      dma_kind,
	output logic                            dma_save_flash,
	output logic [cdma_pkg::AddrW-1:0]      dma_ram_addr,
	output logic [cdma_pkg::DataW-1:0]      dma_cart_addr,
	output logic [cdma_pkg::DmaLenW-1:0]    dma_length
);
	import cdma_pkg::*;

	logic             valid_s1;
	logic [1:0]       opcode_s1;
	logic [OffW-1:0]  offset_s1;
	logic [DataW-1:0] data_s1;
	logic             advance;
	logic             take;
	res_t             res;
	res_t             res_q;

	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take     = in_valid && !in_stall;

	cdma_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.commit     (advance),
		.opcode     (opcode_s1),
		.reg_offset (offset_s1),
		.write_data (data_s1),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			opcode_s1 <= opcode;
			offset_s1 <= reg_offset;
			data_s1   <= write_data;
		end
		if (advance) begin
			res_q <= res;
		end
	end

	assign read_data      = res_q.read_data;
	assign access_ok      = res_q.access_ok;
	assign raise_irq      = res_q.raise_irq;
	assign clear_irq      = res_q.clear_irq;
	assign dma_kind       = res_q.dma_kind;
	assign dma_save_flash = res_q.dma_save_flash;
	assign dma_ram_addr   = res_q.dma_ram_addr;
	assign dma_cart_addr  = res_q.dma_cart_addr;
	assign dma_length     = res_q.dma_length;

endmodule

`default_nettype wire

// ===== hdl/cdma_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cdma_regs (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_wen,
	input  wire  [1:0]                     cfg_wdata,
	input  wire                            commit,
	input  wire  [1:0]                     opcode,
	input  wire  [cdma_pkg::OffW-1:0]      reg_offset,
	input  wire  [cdma_pkg::DataW-1:0]     write_data,
	output cdma_pkg::res_t                 res
);
	import cdma_pkg::*;

	logic [1:0]       storage_kind_q;
	logic [AddrW-1:0] ram_address_q;
	logic [DataW-1:0] cart_address_q;
	logic [LenW-1:0]  to_cart_length_q;
	logic [LenW-1:0]  to_ram_length_q;
	logic [1:0]       busy_q;
	logic [7:0]       latency_q [2];
	logic [7:0]       pulse_width_q [2];
	logic [3:0]       page_size_q [2];
	logic             release_q [2];

	logic             save_dev;
	logic             flash;
	logic             in_save;
	logic             in_rom;
	logic [LenW-1:0]  wr_len;
	logic             set_busy;

	assign save_dev = (storage_kind_q == SK_SRAM) || (storage_kind_q == SK_FLASH);
	assign flash    = (storage_kind_q == SK_FLASH);
	assign in_save  = (cart_address_q >= SAVE_LO) && (cart_address_q <= SAVE_HI);
	assign in_rom   = (cart_address_q >= ROM_LO) && (cart_address_q <= ROM_HI);
	assign wr_len   = write_data[LenW-1:0];
	assign set_busy = !in_save && in_rom;

	always_comb begin
		res = '0;
		case (opcode)
			OP_READ: begin
				res.access_ok = 1'b1;
				unique case (reg_offset)
					REG_RAM_ADDR:  res.read_data = {8'd0, ram_address_q};
					REG_CART_ADDR: res.read_data = cart_address_q;
					REG_TO_CART:   res.read_data = {8'd0, to_cart_length_q};
					REG_TO_RAM:    res.read_data = {8'd0, to_ram_length_q};
					REG_STATUS:    res.read_data = {30'd0, busy_q};
					REG_LAT0:      res.read_data = {24'd0, latency_q[0]};
					REG_PWD0:      res.read_data = {24'd0, pulse_width_q[0]};
					REG_PGS0:      res.read_data = {28'd0, page_size_q[0]};
					REG_RLS0:      res.read_data = {31'd0, release_q[0]};
					REG_LAT1:      res.read_data = {24'd0, latency_q[1]};
					REG_PWD1:      res.read_data = {24'd0, pulse_width_q[1]};
					REG_PGS1:      res.read_data = {28'd0, page_size_q[1]};
					REG_RLS1:      res.read_data = {31'd0, release_q[1]};
					default:       res.access_ok = 1'b0;
				endcase
			end
			OP_WRITE: begin
				res.access_ok = 1'b1;
				res.dma_ram_addr  = ram_address_q;
				res.dma_cart_addr = cart_address_q;
				res.dma_length    = {1'b0, wr_len} + DmaLenW'(1);
				unique case (reg_offset)
					REG_TO_CART: begin
						res.raise_irq = 1'b1;
						if (in_save && save_dev) begin
							res.dma_kind       = DK_TO_SAVE;
							res.dma_save_flash = flash;
						end
					end
					REG_TO_RAM: begin
						if (in_save) begin
							res.raise_irq = 1'b1;
							if (save_dev) begin
								res.dma_kind       = DK_FROM_SAVE;
								res.dma_save_flash = flash;
							end
						end else if (in_rom) begin
							res.dma_kind = DK_ROM;
						end else begin
							res.raise_irq = 1'b1;
						end
					end
					REG_STATUS:    res.clear_irq = write_data[1];
					REG_RAM_ADDR, REG_CART_ADDR, REG_LAT0, REG_PWD0, REG_PGS0, REG_RLS0,
					REG_LAT1, REG_PWD1, REG_PGS1, REG_RLS1: ;
					default:       res.access_ok = 1'b0;
				endcase
				if (res.dma_kind == DK_NONE) begin
					res.dma_ram_addr  = '0;
					res.dma_cart_addr = '0;
					res.dma_length    = '0;
				end
			end
			OP_DONE: begin
				res.access_ok = 1'b1;
				res.raise_irq = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			storage_kind_q   <= SK_NONE;
			ram_address_q    <= '0;
			cart_address_q   <= '0;
			to_cart_length_q <= '0;
			to_ram_length_q  <= '0;
			busy_q           <= '0;
			latency_q[0]     <= '0;
			latency_q[1]     <= '0;
			pulse_width_q[0] <= '0;
			pulse_width_q[1] <= '0;
			page_size_q[0]   <= '0;
			page_size_q[1]   <= '0;
			release_q[0]     <= 1'b0;
			release_q[1]     <= 1'b0;
		end else begin
			if (cfg_wen) begin
				storage_kind_q <= cfg_wdata;
			end
			if (commit && opcode == OP_DONE) begin
				busy_q <= '0;
			end
			if (commit && opcode == OP_WRITE) begin
				unique case (reg_offset)
					REG_RAM_ADDR:  ram_address_q    <= write_data[AddrW-1:0];
					REG_CART_ADDR: cart_address_q   <= write_data;
					REG_TO_CART:   to_cart_length_q <= wr_len;
					REG_TO_RAM: begin
						to_ram_length_q <= wr_len;
						if (set_busy) begin
							busy_q <= 2'b11;
						end
					end
					REG_LAT0:      latency_q[0]     <= write_data[7:0];
					REG_PWD0:      pulse_width_q[0] <= write_data[7:0];
					REG_PGS0:      page_size_q[0]   <= write_data[3:0];
					REG_RLS0:      release_q[0]     <= write_data[0];
					REG_LAT1:      latency_q[1]     <= write_data[7:0];
					REG_PWD1:      pulse_width_q[1] <= write_data[7:0];
					REG_PGS1:      page_size_q[1]   <= write_data[3:0];
					REG_RLS1:      release_q[1]     <= write_data[0];
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import cdma_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int          HOLD_CYCLES = 500;
	localparam int          PHASE_WORDS = 100;
	localparam logic [1:0]  SK_UNUSED   = 2'd3;
	localparam logic [1:0]  OP_SPARE    = 2'd3;
	localparam logic [OffW-1:0] REG_UNMAPPED_LO = 6'h34;
	localparam logic [OffW-1:0] REG_UNMAPPED_HI = 6'h3F;

	typedef struct {
		logic [1:0]       op;
		logic [OffW-1:0]  off;
		logic [DataW-1:0] data;
	} access_t;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wen = 1'b0;
	logic [1:0]          cfg_wdata = SK_NONE;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [1:0]          opcode = OP_READ;
	logic [OffW-1:0]     reg_offset = '0;
	logic [DataW-1:0]    write_data = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [DataW-1:0]    read_data;
	logic                access_ok;
	logic                raise_irq;
	logic                clear_irq;
	logic [1:0]          dma_kind;
	logic                dma_save_flash;
	logic [AddrW-1:0]    dma_ram_addr;
	logic [DataW-1:0]    dma_cart_addr;
	logic [DmaLenW-1:0]  dma_length;

	cart_dma_register_block_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wen        (cfg_wen),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.reg_offset     (reg_offset),
		.write_data     (write_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.read_data      (read_data),
		.access_ok      (access_ok),
		.raise_irq      (raise_irq),
		.clear_irq      (clear_irq),
		.dma_kind       (dma_kind),
		.dma_save_flash (dma_save_flash),
		.dma_ram_addr   (dma_ram_addr),
		.dma_cart_addr  (dma_cart_addr),
		.dma_length     (dma_length)
	);

	initial forever #10 clk = ~clk;

	// register file mirror
	logic [1:0]       storage_q = SK_NONE;
	logic [AddrW-1:0] ram_addr_q = '0;
	logic [DataW-1:0] cart_addr_q = '0;
	logic [LenW-1:0]  to_cart_len_q = '0;
	logic [LenW-1:0]  to_ram_len_q = '0;
	logic [1:0]       busy_q = '0;
	logic [7:0]       latency_q [0:1] = '{8'd0, 8'd0};
	logic [7:0]       pulse_q [0:1] = '{8'd0, 8'd0};
	logic [3:0]       page_q [0:1] = '{4'd0, 4'd0};
	logic             release_q [0:1] = '{1'b0, 1'b0};

	access_t          pending_words [$];
	res_t             expected_results [$];
	logic [OffW-1:0]  mapped_regs [0:12];
	int               mismatches = 0;
	int unsigned      cycle_count = 0;
	bit               in_done = 1'b0;
	int               burst_left = 0;
	int               gap_left = 0;
	bit               hold_go = 1'b0;
	int               hold_cnt = 0;
	int               mode_cnt = 0;
	stall_mode_t      stall_mode = STALL_NONE;

	function automatic res_t transfer_fields(logic [1:0] kind, logic flash, logic [LenW-1:0] len);
		res_t r;
		r = '0;
		r.dma_kind       = kind;
		r.dma_save_flash = flash;
		r.dma_ram_addr   = ram_addr_q;
		r.dma_cart_addr  = cart_addr_q;
		r.dma_length     = {1'b0, len} + 25'd1;
		return r;
	endfunction

	function automatic res_t predict_access(logic [1:0] op, logic [OffW-1:0] off,
			logic [DataW-1:0] d);
		res_t r;
		logic hit;
		logic save_dev;
		logic flash;
		logic in_save;
		logic in_rom;
		r        = '0;
		hit      = 1'b1;
		save_dev = (storage_q == SK_SRAM) || (storage_q == SK_FLASH);
		flash    = (storage_q == SK_FLASH);
		in_save  = (cart_addr_q >= SAVE_LO) && (cart_addr_q <= SAVE_HI);
		in_rom   = (cart_addr_q >= ROM_LO) && (cart_addr_q <= ROM_HI);
		case (op)
		OP_READ: begin
			case (off)
			REG_RAM_ADDR:  r.read_data = {8'd0, ram_addr_q};
			REG_CART_ADDR: r.read_data = cart_addr_q;
			REG_TO_CART:   r.read_data = {8'd0, to_cart_len_q};
			REG_TO_RAM:    r.read_data = {8'd0, to_ram_len_q};
			REG_STATUS:    r.read_data = {30'd0, busy_q};
			REG_LAT0:      r.read_data = {24'd0, latency_q[0]};
			REG_PWD0:      r.read_data = {24'd0, pulse_q[0]};
			REG_PGS0:      r.read_data = {28'd0, page_q[0]};
			REG_RLS0:      r.read_data = {31'd0, release_q[0]};
			REG_LAT1:      r.read_data = {24'd0, latency_q[1]};
			REG_PWD1:      r.read_data = {24'd0, pulse_q[1]};
			REG_PGS1:      r.read_data = {28'd0, page_q[1]};
			REG_RLS1:      r.read_data = {31'd0, release_q[1]};
			default:       hit = 1'b0;
			endcase
		end
		OP_WRITE: begin
			case (off)
			REG_RAM_ADDR:  ram_addr_q = d[AddrW-1:0];
			REG_CART_ADDR: cart_addr_q = d;
			REG_TO_CART: begin
				to_cart_len_q = d[LenW-1:0];
				if (in_save && save_dev)
					r = transfer_fields(DK_TO_SAVE, flash, d[LenW-1:0]);
				r.raise_irq = 1'b1;
			end
			REG_TO_RAM: begin
				to_ram_len_q = d[LenW-1:0];
				if (in_save) begin
					if (save_dev)
						r = transfer_fields(DK_FROM_SAVE, flash, d[LenW-1:0]);
					r.raise_irq = 1'b1;
				end else if (in_rom) begin
					busy_q = 2'b11;
					r = transfer_fields(DK_ROM, 1'b0, d[LenW-1:0]);
				end else begin
					r.raise_irq = 1'b1;
				end
			end
			REG_STATUS:    r.clear_irq = d[1];
			REG_LAT0:      latency_q[0] = d[7:0];
			REG_PWD0:      pulse_q[0] = d[7:0];
			REG_PGS0:      page_q[0] = d[3:0];
			REG_RLS0:      release_q[0] = d[0];
			REG_LAT1:      latency_q[1] = d[7:0];
			REG_PWD1:      pulse_q[1] = d[7:0];
			REG_PGS1:      page_q[1] = d[3:0];
			REG_RLS1:      release_q[1] = d[0];
			default:       hit = 1'b0;
			endcase
		end
		OP_DONE: begin
			busy_q      = 2'b00;
			r.raise_irq = 1'b1;
		end
		default: hit = 1'b0;
		endcase
		r.access_ok = hit;
		return r;
	endfunction

	task automatic compare_field(string name, logic [DataW-1:0] want, logic [DataW-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// record accepted words, then check delivered results
	always @(posedge clk) begin : monitor_proc
		res_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** cart_dma_register_block_core: FAILED **");
			$finish;
		end else if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(predict_access(opcode, reg_offset, write_data));
				in_done = 1'b1;
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result word, read_data %h dma_kind %0d",
						$time, read_data, dma_kind);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					compare_field("read_data", want.read_data, read_data);
					compare_field("access_ok", DataW'(want.access_ok), DataW'(access_ok));
					compare_field("raise_irq", DataW'(want.raise_irq), DataW'(raise_irq));
					compare_field("clear_irq", DataW'(want.clear_irq), DataW'(clear_irq));
					compare_field("dma_kind", DataW'(want.dma_kind), DataW'(dma_kind));
					compare_field("dma_save_flash", DataW'(want.dma_save_flash),
						DataW'(dma_save_flash));
					compare_field("dma_ram_addr", DataW'(want.dma_ram_addr),
						DataW'(dma_ram_addr));
					compare_field("dma_cart_addr", want.dma_cart_addr, dma_cart_addr);
					compare_field("dma_length", DataW'(want.dma_length), DataW'(dma_length));
				end
			end
		end
	end

	always @(negedge clk) begin : drive_proc
		access_t w;
		if (arst_n) begin
			if (in_valid && !in_done) begin
				// hold
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				w = pending_words.pop_front();
				opcode     <= w.op;
				reg_offset <= w.off;
				write_data <= w.data;
				in_valid   <= 1'b1;
				in_done = 1'b0;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 30);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : stall_proc
		logic s;
		if (hold_go) begin
			hold_cnt = HOLD_CYCLES;
			hold_go = 1'b0;
		end
		if (mode_cnt == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			mode_cnt = $urandom_range(32, 256);
		end else begin
			mode_cnt--;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			s = 1'b1;
		end else begin
			case (stall_mode)
			STALL_NONE:  s = 1'b0;
			STALL_LIGHT: s = ($urandom_range(0, 3) == 0);
			STALL_HEAVY: s = ($urandom_range(0, 3) != 0);
			default:     s = ~out_stall;
			endcase
		end
		out_stall <= s;
	end

	task automatic push_word(logic [1:0] op, logic [OffW-1:0] off, logic [DataW-1:0] d);
		access_t w;
		w.op   = op;
		w.off  = off;
		w.data = d;
		pending_words.push_back(w);
	endtask

	task automatic wait_idle();
		while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_storage(logic [1:0] kind);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= kind;
		@(negedge clk);
		cfg_wen <= 1'b0;
		storage_q = kind;
	endtask

	function automatic logic [DataW-1:0] pick_cart_addr();
		case ($urandom_range(0, 11))
		0:       return SAVE_LO;
		1:       return SAVE_LO - 1;
		2:       return SAVE_HI;
		3:       return ROM_LO;
		4:       return ROM_HI;
		5:       return ROM_HI + 1;
		6:       return ($urandom_range(0, 1) == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
		7:       return $urandom_range(32'h0500_0000, 32'h07FF_FFFF);
		8:       return $urandom;
		9, 10:   return $urandom_range(SAVE_LO, SAVE_HI);
		default: return $urandom_range(ROM_LO, ROM_HI);
		endcase
	endfunction

	function automatic logic [DataW-1:0] pick_length();
		case ($urandom_range(0, 7))
		0:       return 32'h0000_0000;
		1:       return 32'h00FF_FFFF;
		2:       return 32'hFFFF_FFFF;
		default: return $urandom;
		endcase
	endfunction

	task automatic fill_phase(int n);
		int count;
		count = 0;
		while (count < n) begin
			case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				push_word(OP_WRITE, REG_RAM_ADDR, $urandom);
				push_word(OP_WRITE, REG_CART_ADDR, pick_cart_addr());
				push_word(OP_WRITE, ($urandom_range(0, 1) == 0) ? REG_TO_CART : REG_TO_RAM,
					pick_length());
				count += 3;
				if ($urandom_range(0, 1) == 0) begin
					push_word(OP_READ, REG_STATUS, $urandom);
					count++;
				end
				if ($urandom_range(0, 1) == 0) begin
					push_word(OP_DONE, OffW'($urandom_range(0, 63)), $urandom);
					count++;
				end
				if ($urandom_range(0, 1) == 0) begin
					push_word(OP_WRITE, REG_STATUS, $urandom);
					count++;
				end
			end
			5, 6: begin
				push_word(($urandom_range(0, 1) == 0) ? OP_READ : OP_WRITE,
					mapped_regs[$urandom_range(0, 12)], $urandom);
				count++;
			end
			7: begin
				push_word(OP_READ, mapped_regs[$urandom_range(0, 12)], $urandom);
				count++;
			end
			8: begin
				// broken sequence: address set, length never written
				push_word(OP_WRITE, REG_CART_ADDR, pick_cart_addr());
				push_word(OP_WRITE, OffW'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)),
					$urandom);
				push_word(OP_DONE, OffW'($urandom_range(0, 63)), $urandom);
				count += 3;
			end
			default: begin
				push_word(2'($urandom_range(0, 3)), OffW'($urandom_range(0, 63)), $urandom);
				count++;
			end
			endcase
		end
	endtask

	initial begin : main_proc
		logic [1:0] phase_kinds [0:7];
		mapped_regs = '{REG_RAM_ADDR, REG_CART_ADDR, REG_TO_CART, REG_TO_RAM, REG_STATUS,
			REG_LAT0, REG_PWD0, REG_PGS0, REG_RLS0, REG_LAT1, REG_PWD1, REG_PGS1, REG_RLS1};
		phase_kinds = '{SK_SRAM, SK_FLASH, SK_UNUSED, SK_NONE, SK_FLASH, SK_SRAM,
			SK_FLASH, SK_NONE};
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		set_storage(SK_NONE);
		push_word(OP_READ, REG_UNMAPPED_HI, 32'h0);
		push_word(OP_WRITE, REG_UNMAPPED_LO, 32'hFFFF_FFFF);
		push_word(OP_WRITE, REG_RAM_ADDR, 32'hFFFF_FFFF);
		push_word(OP_WRITE, REG_CART_ADDR, SAVE_LO);
		push_word(OP_WRITE, REG_TO_CART, 32'hFFFF_FFFF);
		push_word(OP_WRITE, REG_TO_RAM, 32'h0);
		push_word(OP_WRITE, REG_CART_ADDR, ROM_HI);
		push_word(OP_WRITE, REG_TO_RAM, 32'hFFFF_FFFF);
		push_word(OP_READ, REG_STATUS, 32'h0);
		push_word(OP_DONE, 6'h00, 32'h0);
		push_word(OP_DONE, REG_UNMAPPED_HI, 32'hFFFF_FFFF);
		push_word(OP_WRITE, REG_STATUS, 32'h0000_0002);
		push_word(OP_WRITE, REG_STATUS, 32'hFFFF_FFFD);
		push_word(OP_SPARE, REG_UNMAPPED_HI, 32'hFFFF_FFFF);
		push_word(OP_WRITE, REG_LAT1, 32'hFFFF_FFFF);
		push_word(OP_READ, REG_LAT1, 32'h0);
		push_word(OP_READ, REG_RAM_ADDR, 32'h0);
		wait_idle();

		set_storage(SK_FLASH);
		push_word(OP_WRITE, REG_CART_ADDR, SAVE_HI);
		push_word(OP_WRITE, REG_TO_CART, 32'h0);
		push_word(OP_WRITE, REG_TO_RAM, 32'h00FF_FFFF);
		push_word(OP_WRITE, REG_CART_ADDR, SAVE_LO - 1);
		push_word(OP_WRITE, REG_TO_RAM, 32'h5);
		push_word(OP_WRITE, REG_CART_ADDR, ROM_HI + 1);
		push_word(OP_WRITE, REG_TO_RAM, 32'h7);
		push_word(OP_WRITE, REG_CART_ADDR, ROM_LO);
		push_word(OP_WRITE, REG_TO_CART, 32'h9);
		push_word(OP_READ, REG_CART_ADDR, 32'h0);
		wait_idle();

		for (int p = 0; p < 8; p++) begin
			set_storage(phase_kinds[p]);
			if (p == 1 || p == 5)
				hold_go = 1'b1;
			fill_phase(PHASE_WORDS);
			wait_idle();
		end

		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("** cart_dma_register_block_core: PASSED **");
		else
			$display("** cart_dma_register_block_core: FAILED **");
		$finish;
	end

endmodule
